[rtl/core/wbrm_pkg.sv]
// Shared types and constants for the windowed byte rate meter.
// No dependencies; the interfaces and the top level refer to this package.
`default_nettype none

package wbrm_pkg;

  localparam int unsigned CELLS_DEF = 60;

  localparam int unsigned OPCODE_W  = 3;
  localparam int unsigned SEC_W     = 32;
  localparam int unsigned MICRO_W   = 20;
  localparam int unsigned BYTES_W   = 32;
  localparam int unsigned RATE_W    = 32;
  localparam int unsigned COUNT_W   = 16;
  localparam int unsigned MS_W      = 32;

  // Seconds to milliseconds: multiply by 1000, a 10-bit constant.
  localparam int unsigned MS_PER_S  = 1000;
  localparam int unsigned MS_MUL_W  = 10;

  // Microseconds to milliseconds: floor(x / 1000) == (x * ceil(2^30 / 1000)) >> 30
  // for every x below 2^20.
  localparam int unsigned US_RECIP_W     = 21;
  localparam logic [US_RECIP_W-1:0] US_RECIP = 21'd1073742;
  localparam int unsigned US_RECIP_SHIFT = 30;
  localparam int unsigned US_PROD_W      = MICRO_W + US_RECIP_W;
  localparam int unsigned DMS_W          = US_PROD_W - US_RECIP_SHIFT;

  typedef enum logic [OPCODE_W-1:0] {
    OP_TICK     = 3'd0,
    OP_BYTES    = 3'd1,
    OP_JOIN     = 3'd2,
    OP_ACTIVATE = 3'd3,
    OP_LEAVE    = 3'd4,
    OP_RESTART  = 3'd5
  } op_e;

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_MUL  = 6'b000010,
    ST_ELAP = 6'b000100,
    ST_WALK = 6'b001000,
    ST_DIV  = 6'b010000,
    ST_FIN  = 6'b100000
  } state_e;

endpackage

`default_nettype wire

[rtl/core/wbrm_if.sv]
// Valid/ready channel interfaces for the meter's event input and rate output.
// Depends on wbrm_pkg for field widths.
`default_nettype none

interface wbrm_in_if;
  logic                          valid;
  logic                          ready;
  logic [wbrm_pkg::OPCODE_W-1:0] opcode;
  logic [wbrm_pkg::SEC_W-1:0]    time_seconds;
  logic [wbrm_pkg::MICRO_W-1:0]  time_micros;
  logic [wbrm_pkg::BYTES_W-1:0]  byte_count;
  logic                          was_active;

  modport source (
    output valid, opcode, time_seconds, time_micros, byte_count, was_active,
    input  ready
  );
  modport sink (
    input  valid, opcode, time_seconds, time_micros, byte_count, was_active,
    output ready
  );
endinterface

interface wbrm_out_if;
  logic                        valid;
  logic                        ready;
  logic [wbrm_pkg::RATE_W-1:0] rate;
  logic                        rate_changed;

  modport source (
    output valid, rate, rate_changed,
    input  ready
  );
  modport sink (
    input  valid, rate, rate_changed,
    output ready
  );
endinterface

`default_nettype wire

[rtl/core/windowed_byte_rate_meter.sv]
// Windowed byte rate meter: byte, join, activate, leave and restart events take effect
// on accept and leave the input ready. Ticks that reset the ring or restamp the cell go
// straight to FIN, which publishes once the output slot is free. Input waits while a
// closing tick runs MUL, ELAP, WALK over the W window cells, DIV (DVD_W = 48 at 60 cells;
// skipped if window time is not positive) and FIN: one RAM read, one quotient bit per cycle.
// Reset clears indices, counts, cell stamp and rate at once; the cell RAM needs no clear.
`default_nettype none

module windowed_byte_rate_meter #(
  parameter int unsigned CELLS = wbrm_pkg::CELLS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  wbrm_in_if.sink           in_i,
  wbrm_out_if.source        out_o
);

  localparam int unsigned IDX_W  = $clog2(CELLS);
  localparam int unsigned SUM_XW = $clog2(CELLS);
  localparam int unsigned BSUM_W = wbrm_pkg::BYTES_W + SUM_XW;
  localparam int unsigned MSUM_W = wbrm_pkg::MS_W + SUM_XW + 1;
  localparam int unsigned DVD_W  = BSUM_W + wbrm_pkg::MS_MUL_W;
  localparam int unsigned DVS_W  = MSUM_W - 1;
  localparam int unsigned CELL_W = wbrm_pkg::MS_W + wbrm_pkg::BYTES_W;
  localparam int unsigned SECP_W = wbrm_pkg::SEC_W + wbrm_pkg::MS_MUL_W;

  localparam int unsigned SEC_W   = wbrm_pkg::SEC_W;
  localparam int unsigned MICRO_W = wbrm_pkg::MICRO_W;
  localparam int unsigned BYTES_W = wbrm_pkg::BYTES_W;
  localparam int unsigned RATE_W  = wbrm_pkg::RATE_W;
  localparam int unsigned COUNT_W = wbrm_pkg::COUNT_W;
  localparam int unsigned MS_W    = wbrm_pkg::MS_W;
  localparam int unsigned PROD_W  = wbrm_pkg::US_PROD_W;
  localparam int unsigned DMS_W   = wbrm_pkg::DMS_W;
  localparam int unsigned US_RECIP_W_PAD = PROD_W - MICRO_W;

  function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] idx);
    next_idx = (idx == IDX_W'(CELLS - 1)) ? '0 : idx + IDX_W'(1);
  endfunction

  wbrm_pkg::state_e state_q, state_d;

  logic [IDX_W-1:0]   oldest_q, oldest_d;
  logic [IDX_W-1:0]   cur_q, cur_d;
  logic [SEC_W-1:0]   start_sec_q, start_sec_d;
  logic [MICRO_W-1:0] start_mic_q, start_mic_d;
  logic [BYTES_W-1:0] cur_bytes_q, cur_bytes_d;
  logic [COUNT_W-1:0] joined_q, joined_d;
  logic [COUNT_W-1:0] active_q, active_d;
  logic [RATE_W-1:0]  rate_q, rate_d;
  logic               ring_reset_q, ring_reset_d;
  logic               close_q, close_d;
  logic               rd_vld_q, rd_vld_d;
  logic               out_valid_q, out_valid_d;

  logic [SEC_W-1:0]   tick_sec_q, tick_sec_d;
  logic [MICRO_W-1:0] tick_mic_q, tick_mic_d;
  logic [MS_W-1:0]    sec_ms_q, sec_ms_d;
  logic [PROD_W-1:0]  us_prod_q, us_prod_d;
  logic               neg_q, neg_d;
  logic [MSUM_W-1:0]  ms_sum_q, ms_sum_d;
  logic [BSUM_W-1:0]  byte_sum_q, byte_sum_d;
  logic [IDX_W-1:0]   rd_idx_q, rd_idx_d;
  logic [RATE_W-1:0]  new_rate_q, new_rate_d;
  logic [RATE_W-1:0]  rate_out_q, rate_out_d;
  logic               changed_q, changed_d;

  logic               in_fire;
  logic               cur_nonzero;
  logic [BYTES_W:0]   byte_add;
  logic [SEC_W-1:0]   sec_diff;
  logic [SECP_W-1:0]  sec_prod;
  logic [MICRO_W:0]   mic_diff;
  logic [MICRO_W:0]   mic_mag;
  logic [DMS_W-1:0]   dms_mag;
  logic [MS_W-1:0]    dms;
  logic [MS_W-1:0]    elapsed;
  logic               rd_issue;
  logic               walk_end;
  logic               ms_pos;
  logic               ram_we;
  logic [CELL_W-1:0]  ram_rdata;
  logic [MS_W-1:0]    rd_ms;
  logic [BYTES_W-1:0] rd_bytes;
  logic [DVD_W-1:0]   dividend;
  logic               div_start;
  logic               div_done;
  logic [DVD_W-1:0]   quotient;
  logic [IDX_W-1:0]   cur_next;

  assign in_i.ready  = (state_q == wbrm_pkg::ST_IDLE);
  assign in_fire     = in_i.valid & in_i.ready;
  assign cur_nonzero = (cur_bytes_q != '0);
  assign byte_add    = {1'b0, cur_bytes_q} + {1'b0, in_i.byte_count};

  // elapsed ms of the closing cell: whole seconds times 1000 plus truncated micro delta
  assign sec_diff = tick_sec_q - start_sec_q;
  assign sec_prod = {{wbrm_pkg::MS_MUL_W{1'b0}}, sec_diff} * SECP_W'(wbrm_pkg::MS_PER_S);
  assign mic_diff = {1'b0, tick_mic_q} - {1'b0, start_mic_q};
  assign mic_mag  = mic_diff[MICRO_W] ? (~mic_diff + (MICRO_W+1)'(1)) : mic_diff;
  assign dms_mag  = us_prod_q[PROD_W-1:wbrm_pkg::US_RECIP_SHIFT];
  assign dms      = neg_q ? (~MS_W'(dms_mag) + MS_W'(1)) : MS_W'(dms_mag);
  assign elapsed  = sec_ms_q + dms;

  assign rd_issue = (state_q == wbrm_pkg::ST_WALK) && (rd_idx_q != cur_q);
  assign walk_end = !rd_issue && !rd_vld_q;
  assign ms_pos   = !ms_sum_q[MSUM_W-1] && (ms_sum_q != '0);
  assign ram_we   = (state_q == wbrm_pkg::ST_ELAP);
  assign rd_ms    = ram_rdata[CELL_W-1:BYTES_W];
  assign rd_bytes = ram_rdata[BYTES_W-1:0];
  assign cur_next = next_idx(cur_q);

  // bytes * 1000 as shifts and subtracts
  assign dividend = {byte_sum_q, 10'b0}
                  - {6'b0, byte_sum_q, 4'b0}
                  - {7'b0, byte_sum_q, 3'b0};
  assign div_start = (state_q == wbrm_pkg::ST_WALK) && walk_end && ms_pos;

  wbrm_ram #(
    .WIDTH (CELL_W),
    .DEPTH (CELLS)
  ) u_cell_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (cur_q),
    .wdata_i ({elapsed, cur_bytes_q}),
    .raddr_i (rd_idx_q),
    .rdata_o (ram_rdata)
  );

  wbrm_div #(
    .DVD_W (DVD_W),
    .DVS_W (DVS_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (dividend),
    .divisor_i  (ms_sum_q[DVS_W-1:0]),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  always_comb begin
    state_d      = state_q;
    oldest_d     = oldest_q;
    cur_d        = cur_q;
    start_sec_d  = start_sec_q;
    start_mic_d  = start_mic_q;
    cur_bytes_d  = cur_bytes_q;
    joined_d     = joined_q;
    active_d     = active_q;
    rate_d       = rate_q;
    ring_reset_d = ring_reset_q;
    close_d      = close_q;
    rd_vld_d     = rd_issue;
    out_valid_d  = out_valid_q && !out_o.ready;
    tick_sec_d   = tick_sec_q;
    tick_mic_d   = tick_mic_q;
    sec_ms_d     = sec_prod[MS_W-1:0];
    us_prod_d    = {{US_RECIP_W_PAD{1'b0}}, mic_mag[MICRO_W-1:0]}
                 * PROD_W'(wbrm_pkg::US_RECIP);
    neg_d        = mic_diff[MICRO_W];
    ms_sum_d     = ms_sum_q;
    byte_sum_d   = byte_sum_q;
    rd_idx_d     = rd_issue ? next_idx(rd_idx_q) : rd_idx_q;
    new_rate_d   = new_rate_q;
    rate_out_d   = rate_out_q;
    changed_d    = changed_q;

    case (state_q)
      wbrm_pkg::ST_IDLE: begin
        if (in_fire) begin
          case (wbrm_pkg::op_e'(in_i.opcode))
            wbrm_pkg::OP_TICK: begin
              tick_sec_d   = in_i.time_seconds;
              tick_mic_d   = in_i.time_micros;
              new_rate_d   = rate_q;
              ring_reset_d = 1'b0;
              close_d      = 1'b0;
              if (joined_q == '0 && !cur_nonzero) begin
                ring_reset_d = 1'b1;
                state_d      = wbrm_pkg::ST_FIN;
              end else if (joined_q != '0 && active_q == '0 && !cur_nonzero) begin
                state_d = wbrm_pkg::ST_FIN;
              end else begin
                close_d = 1'b1;
                state_d = wbrm_pkg::ST_MUL;
              end
            end
            wbrm_pkg::OP_BYTES: begin
              cur_bytes_d = byte_add[BYTES_W] ? '1 : byte_add[BYTES_W-1:0];
            end
            wbrm_pkg::OP_JOIN: begin
              if (joined_q != '1) begin
                joined_d = joined_q + COUNT_W'(1);
              end
            end
            wbrm_pkg::OP_ACTIVATE: begin
              if (active_q != '1) begin
                active_d = active_q + COUNT_W'(1);
              end
            end
            wbrm_pkg::OP_LEAVE: begin
              if (joined_q != '0) begin
                joined_d = joined_q - COUNT_W'(1);
              end
              if (in_i.was_active && active_q != '0) begin
                active_d = active_q - COUNT_W'(1);
              end
            end
            wbrm_pkg::OP_RESTART: begin
              oldest_d    = '0;
              cur_d       = '0;
              start_sec_d = in_i.time_seconds;
              start_mic_d = in_i.time_micros;
              cur_bytes_d = '0;
            end
            default: begin
            end
          endcase
        end
      end
      wbrm_pkg::ST_MUL: begin
        state_d = wbrm_pkg::ST_ELAP;
      end
      wbrm_pkg::ST_ELAP: begin
        // the current cell goes into the window sums straight from registers
        ms_sum_d   = {{(MSUM_W-MS_W){elapsed[MS_W-1]}}, elapsed};
        byte_sum_d = {{SUM_XW{1'b0}}, cur_bytes_q};
        rd_idx_d   = oldest_q;
        rd_vld_d   = 1'b0;
        state_d    = wbrm_pkg::ST_WALK;
      end
      wbrm_pkg::ST_WALK: begin
        if (rd_vld_q) begin
          ms_sum_d   = ms_sum_q + {{(MSUM_W-MS_W){rd_ms[MS_W-1]}}, rd_ms};
          byte_sum_d = byte_sum_q + {{SUM_XW{1'b0}}, rd_bytes};
        end
        if (walk_end) begin
          if (ms_pos) begin
            state_d = wbrm_pkg::ST_DIV;
          end else begin
            new_rate_d = rate_q;
            state_d    = wbrm_pkg::ST_FIN;
          end
        end
      end
      wbrm_pkg::ST_DIV: begin
        if (div_done) begin
          new_rate_d = (quotient[DVD_W-1:RATE_W] != '0) ? '1 : quotient[RATE_W-1:0];
          state_d    = wbrm_pkg::ST_FIN;
        end
      end
      wbrm_pkg::ST_FIN: begin
        // hold until the output slot is free, then publish and open the new cell
        if (!out_valid_q || out_o.ready) begin
          out_valid_d = 1'b1;
          rate_out_d  = new_rate_q;
          changed_d   = (new_rate_q != rate_q);
          rate_d      = new_rate_q;
          start_sec_d = tick_sec_q;
          start_mic_d = tick_mic_q;
          cur_bytes_d = '0;
          if (ring_reset_q) begin
            oldest_d = '0;
            cur_d    = '0;
          end else if (close_q) begin
            cur_d = cur_next;
            if (cur_next == oldest_q) begin
              oldest_d = next_idx(oldest_q);
            end
          end
          state_d = wbrm_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = wbrm_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= wbrm_pkg::ST_IDLE;
      oldest_q     <= '0;
      cur_q        <= '0;
      start_sec_q  <= '0;
      start_mic_q  <= '0;
      cur_bytes_q  <= '0;
      joined_q     <= '0;
      active_q     <= '0;
      rate_q       <= '0;
      ring_reset_q <= 1'b0;
      close_q      <= 1'b0;
      rd_vld_q     <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      oldest_q     <= oldest_d;
      cur_q        <= cur_d;
      start_sec_q  <= start_sec_d;
      start_mic_q  <= start_mic_d;
      cur_bytes_q  <= cur_bytes_d;
      joined_q     <= joined_d;
      active_q     <= active_d;
      rate_q       <= rate_d;
      ring_reset_q <= ring_reset_d;
      close_q      <= close_d;
      rd_vld_q     <= rd_vld_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tick_sec_q <= tick_sec_d;
    tick_mic_q <= tick_mic_d;
    sec_ms_q   <= sec_ms_d;
    us_prod_q  <= us_prod_d;
    neg_q      <= neg_d;
    ms_sum_q   <= ms_sum_d;
    byte_sum_q <= byte_sum_d;
    rd_idx_q   <= rd_idx_d;
    new_rate_q <= new_rate_d;
    rate_out_q <= rate_out_d;
    changed_q  <= changed_d;
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.rate         = rate_out_q;
  assign out_o.rate_changed = changed_q;

`ifndef SYNTHESIS
  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cur_q <= IDX_W'(CELLS - 1)) && (oldest_q <= IDX_W'(CELLS - 1)))
    else $error("ring index out of range");

  a_div_positive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> (!ms_sum_q[MSUM_W-1] && ms_sum_q != '0))
    else $error("divider started with non-positive elapsed time");

  a_div_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == wbrm_pkg::ST_DIV))
    else $error("divider finished outside the divide state");

  a_result_from_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == wbrm_pkg::ST_FIN))
    else $error("result published outside the finish state");

  a_no_read_of_current: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == wbrm_pkg::ST_ELAP) |=> (rd_idx_q == oldest_q && !rd_vld_q))
    else $error("window walk did not start at the oldest cell");
`endif

endmodule

`default_nettype wire

[rtl/core/wbrm_ram.sv]
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module wbrm_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 60
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[rtl/core/wbrm_div.sv]
// Restoring divider, one quotient bit per cycle, for the rate quotient.
// No package dependencies; widths come from the top level.
`default_nettype none

module wbrm_div #(
  parameter int unsigned DVD_W = 48,
  parameter int unsigned DVS_W = 38
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DVD_W-1:0] dividend_i,
  input  logic [DVS_W-1:0] divisor_i,
  output logic             done_o,
  output logic [DVD_W-1:0] quotient_o
);

  localparam int unsigned CNT_W = $clog2(DVD_W + 1);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [DVS_W-1:0] rem_q, rem_d;
  logic [DVD_W-1:0] quo_q, quo_d;

  logic [DVS_W:0]   rem_sh;
  logic [DVS_W+1:0] diff;
  logic             fits;

  assign rem_sh = {rem_q, quo_q[DVD_W-1]};
  assign diff   = {1'b0, rem_sh} - {2'b00, divisor_i};
  assign fits   = ~diff[DVS_W+1];

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(DVD_W);
      rem_d  = '0;
      quo_d  = dividend_i;
    end else if (busy_q) begin
      // shift in the next dividend bit, subtract when it fits
      rem_d = fits ? diff[DVS_W-1:0] : rem_sh[DVS_W-1:0];
      quo_d = {quo_q[DVD_W-2:0], fits};
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

`default_nettype wire
